// ===== rtl/ddo_pkg.sv =====
package ddo_pkg;

  // Field and register widths
  localparam int COUNT_WIDTH = 32;   // encoder bits used, 16..32
  localparam int TRIG_BITS   = 16;   // sin/cos fraction bits, 10..24
  localparam int CFG_W       = 32;
  localparam int POS_W       = 32;
  localparam int ANG_W       = 32;
  localparam int KIND_W      = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_DATA_W   = 96;   // left, right, position_value
  localparam int OUT_DATA_W  = 96;   // x, y, heading

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_ENC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SET_X = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SET_Y = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIST = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD = 1'd1;

  // Shared multiplier
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;

  // Datapath widths
  localparam int SUM_W      = COUNT_WIDTH + 1;
  localparam int HD_W       = ANG_W + 1;
  localparam int DIST_SHIFT = 8;
  localparam int DSM_W      = COUNT_WIDTH + CFG_W - DIST_SHIFT;
  localparam int DSM_HI_W   = DSM_W - MUL_W;
  localparam int U_W        = ANG_W - 2;
  localparam int T_W        = 30;
  localparam int P_W        = 31;
  localparam int Q_FRAC     = 30;
  localparam int TRIG_W     = TRIG_BITS + 1;
  localparam int ROUND_POS  = 29 - TRIG_BITS;
  localparam int HI_W       = DSM_HI_W + TRIG_W;
  localparam int HI_KEEP_W  = TRIG_BITS + 2;
  localparam int LO_W       = MUL_W + TRIG_W;
  localparam int FULL_W     = TRIG_BITS + 35;
  localparam int MAG_W      = 35;
  localparam int CAP_POS    = 34;
  localparam int SUMP_W     = 37;

  // Q30 series constants
  localparam logic [P_W-1:0] Q30_ONE     = P_W'(1073741824);
  localparam logic [P_W-1:0] PI_HALF_Q30 = P_W'(1686629713);
  localparam logic [P_W-1:0] S3  = P_W'(178956971);
  localparam logic [P_W-1:0] S5  = P_W'(8947849);
  localparam logic [P_W-1:0] S7  = P_W'(213044);
  localparam logic [P_W-1:0] S9  = P_W'(2959);
  localparam logic [P_W-1:0] K2  = P_W'(536870912);
  localparam logic [P_W-1:0] K4  = P_W'(44739243);
  localparam logic [P_W-1:0] K6  = P_W'(1491308);
  localparam logic [P_W-1:0] K8  = P_W'(26631);
  localparam logic [P_W-1:0] K10 = P_W'(296);

  // Datapath operations
  typedef logic [4:0] op_t;
  localparam op_t OP_NOP    = 5'd0;
  localparam op_t OP_START  = 5'd1;
  localparam op_t OP_PREP   = 5'd2;
  localparam op_t OP_M_DIST = 5'd3;
  localparam op_t OP_W_DSM  = 5'd4;
  localparam op_t OP_M_T    = 5'd5;
  localparam op_t OP_W_T    = 5'd6;
  localparam op_t OP_M_T2   = 5'd7;
  localparam op_t OP_W_T2   = 5'd8;
  localparam op_t OP_M_P    = 5'd9;
  localparam op_t OP_W_PS   = 5'd10;
  localparam op_t OP_W_PC   = 5'd11;
  localparam op_t OP_M_SIN  = 5'd12;
  localparam op_t OP_W_SIN  = 5'd13;
  localparam op_t OP_W_COS  = 5'd14;
  localparam op_t OP_M_HI   = 5'd15;
  localparam op_t OP_W_HI   = 5'd16;
  localparam op_t OP_M_LO   = 5'd17;
  localparam op_t OP_W_POS  = 5'd18;
  localparam op_t OP_M_HEAD = 5'd19;
  localparam op_t OP_W_HEAD = 5'd20;
  localparam op_t OP_SET_X  = 5'd21;
  localparam op_t OP_SET_Y  = 5'd22;

  typedef struct packed {
    op_t        op;
    logic [1:0] idx;       // Horner step
    logic       axis;      // 0: x, 1: y
    logic       load_out;  // copy state into output register
  } dp_cmd_t;

endpackage

// ===== rtl/ddo_ctrl.sv =====
module ddo_ctrl
  import ddo_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  input  logic [KIND_W-1:0] s_kind_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output dp_cmd_t           cmd_o
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_PREP  = 5'd1;
  localparam logic [4:0] S_MDIST = 5'd2;
  localparam logic [4:0] S_WDSM  = 5'd3;
  localparam logic [4:0] S_MT    = 5'd4;
  localparam logic [4:0] S_WT    = 5'd5;
  localparam logic [4:0] S_MT2   = 5'd6;
  localparam logic [4:0] S_WT2   = 5'd7;
  localparam logic [4:0] S_MPS   = 5'd8;
  localparam logic [4:0] S_WPS   = 5'd9;
  localparam logic [4:0] S_MSIN  = 5'd10;
  localparam logic [4:0] S_WSIN  = 5'd11;
  localparam logic [4:0] S_MPC   = 5'd12;
  localparam logic [4:0] S_WPC   = 5'd13;
  localparam logic [4:0] S_MCOS  = 5'd14;
  localparam logic [4:0] S_WCOS  = 5'd15;
  localparam logic [4:0] S_MHI   = 5'd16;
  localparam logic [4:0] S_WHI   = 5'd17;
  localparam logic [4:0] S_MLO   = 5'd18;
  localparam logic [4:0] S_WPOS  = 5'd19;
  localparam logic [4:0] S_MHEAD = 5'd20;
  localparam logic [4:0] S_WHEAD = 5'd21;
  localparam logic [4:0] S_SETX  = 5'd22;
  localparam logic [4:0] S_SETY  = 5'd23;
  localparam logic [4:0] S_DONE  = 5'd24;

  localparam logic [1:0] IDX_LAST = 2'd3;

  logic [4:0] state_q, state_d;
  logic [1:0] idx_q, idx_d;
  logic       axis_q, axis_d;
  logic       mvalid_q, mvalid_d;

  always_comb begin
    state_d        = state_q;
    idx_d          = idx_q;
    axis_d         = axis_q;
    mvalid_d       = mvalid_q & ~m_ready_i;
    cmd_o.op       = OP_NOP;
    cmd_o.idx      = idx_q;
    cmd_o.axis     = axis_q;
    cmd_o.load_out = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.op = OP_START;
          case (s_kind_i)
            KIND_ENC:   state_d = S_PREP;
            KIND_SET_X: state_d = S_SETX;
            KIND_SET_Y: state_d = S_SETY;
            default:    state_d = S_DONE;
          endcase
        end
      end
      S_PREP: begin
        cmd_o.op = OP_PREP;
        state_d  = S_MDIST;
      end
      S_MDIST: begin
        cmd_o.op = OP_M_DIST;
        state_d  = S_WDSM;
      end
      S_WDSM: begin
        cmd_o.op = OP_W_DSM;
        state_d  = S_MT;
      end
      S_MT: begin
        cmd_o.op = OP_M_T;
        state_d  = S_WT;
      end
      S_WT: begin
        cmd_o.op = OP_W_T;
        state_d  = S_MT2;
      end
      S_MT2: begin
        cmd_o.op = OP_M_T2;
        state_d  = S_WT2;
      end
      S_WT2: begin
        cmd_o.op = OP_W_T2;
        idx_d    = '0;
        state_d  = S_MPS;
      end
      S_MPS: begin
        cmd_o.op = OP_M_P;
        state_d  = S_WPS;
      end
      S_WPS: begin
        cmd_o.op = OP_W_PS;
        idx_d    = idx_q + 2'd1;
        state_d  = (idx_q == IDX_LAST) ? S_MSIN : S_MPS;
      end
      S_MSIN: begin
        cmd_o.op = OP_M_SIN;
        state_d  = S_WSIN;
      end
      S_WSIN: begin
        cmd_o.op = OP_W_SIN;
        idx_d    = '0;
        state_d  = S_MPC;
      end
      S_MPC: begin
        cmd_o.op = OP_M_P;
        state_d  = S_WPC;
      end
      S_WPC: begin
        cmd_o.op = OP_W_PC;
        idx_d    = idx_q + 2'd1;
        state_d  = (idx_q == IDX_LAST) ? S_MCOS : S_MPC;
      end
      S_MCOS: begin
        cmd_o.op = OP_M_P;
        state_d  = S_WCOS;
      end
      S_WCOS: begin
        cmd_o.op = OP_W_COS;
        axis_d   = 1'b0;
        state_d  = S_MHI;
      end
      S_MHI: begin
        cmd_o.op = OP_M_HI;
        state_d  = S_WHI;
      end
      S_WHI: begin
        cmd_o.op = OP_W_HI;
        state_d  = S_MLO;
      end
      S_MLO: begin
        cmd_o.op = OP_M_LO;
        state_d  = S_WPOS;
      end
      S_WPOS: begin
        cmd_o.op = OP_W_POS;
        axis_d   = 1'b1;
        state_d  = axis_q ? S_MHEAD : S_MHI;
      end
      S_MHEAD: begin
        cmd_o.op = OP_M_HEAD;
        state_d  = S_WHEAD;
      end
      S_WHEAD: begin
        cmd_o.op = OP_W_HEAD;
        state_d  = S_DONE;
      end
      S_SETX: begin
        cmd_o.op = OP_SET_X;
        state_d  = S_DONE;
      end
      S_SETY: begin
        cmd_o.op = OP_SET_Y;
        state_d  = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!mvalid_q || m_ready_i) begin
          cmd_o.load_out = 1'b1;
          mvalid_d       = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      axis_q   <= 1'b0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      axis_q   <= axis_d;
      mvalid_q <= mvalid_d;
    end
  end

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = mvalid_q;

endmodule

// ===== rtl/ddo_dp.sv =====
module ddo_dp
  import ddo_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  output logic [OUT_DATA_W-1:0] out_data_o
);

  function automatic logic [TRIG_W-1:0] to_trig(logic [P_W-1:0] v);
    logic [MUL_W-1:0] s;
    s = MUL_W'(v) + (MUL_W'(1) << ROUND_POS);
    return s[(Q_FRAC - TRIG_BITS) +: TRIG_W];
  endfunction

  function automatic logic [P_W-1:0] sin_coef(logic [1:0] i);
    logic [P_W-1:0] c;
    case (i)
      2'd0:    c = S7;
      2'd1:    c = S5;
      2'd2:    c = S3;
      default: c = Q30_ONE;
    endcase
    return c;
  endfunction

  function automatic logic [P_W-1:0] cos_coef(logic [1:0] i);
    logic [P_W-1:0] c;
    case (i)
      2'd0:    c = K8;
      2'd1:    c = K6;
      2'd2:    c = K4;
      default: c = K2;
    endcase
    return c;
  endfunction

  // Registers and architectural state
  logic [CFG_W-1:0]        dpt_q, hpt_q;
  logic [COUNT_WIDTH-1:0]  last_l_q, last_r_q;
  logic signed [POS_W-1:0] x_q, y_q;
  logic [ANG_W-1:0]        head_q;

  // Item working registers
  logic [COUNT_WIDTH-1:0]  lc_q, rc_q;
  logic signed [POS_W-1:0] pv_q;
  logic [SUM_W-1:0]        smag_q;
  logic                    sneg_q;
  logic [ANG_W-1:0]        hd_q;
  logic [U_W-1:0]          u_q;
  logic                    swap_q;
  logic [1:0]              quad_q;
  logic [PROD_W-1:0]       prod_q;
  logic [DSM_W-1:0]        dsm_q;
  logic [T_W-1:0]          t_q, t2_q;
  logic [P_W-1:0]          p_q;
  logic [TRIG_W-1:0]       sin_q, cos_q;
  logic                    hi_big_q;
  logic [HI_KEEP_W-1:0]    hi_lo_q;
  logic [OUT_DATA_W-1:0]   out_q;

  // Count differences and heading fold
  logic signed [COUNT_WIDTH-1:0] dl, dr;
  logic signed [SUM_W-1:0]       sum;
  logic [SUM_W-1:0]              smag;
  logic signed [HD_W-1:0]        hdw;
  logic [U_W-1:0]                r_ang, u_ang;
  logic                          fold;

  assign dl    = signed'(lc_q - last_l_q);
  assign dr    = signed'(rc_q - last_r_q);
  assign sum   = SUM_W'(dl) + SUM_W'(dr);
  assign smag  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign hdw   = HD_W'(dl) - HD_W'(dr);
  assign r_ang = head_q[U_W-1:0];
  assign fold  = r_ang > (U_W'(1) << (U_W - 1));
  assign u_ang = fold ? (U_W'(0) - r_ang) : r_ang;  // quarter turn minus r

  // Octant and quadrant mapping
  logic [TRIG_W-1:0] s0, c0, cm, sm, tm;
  logic              cn, sn, step_neg;

  assign s0       = swap_q ? cos_q : sin_q;
  assign c0       = swap_q ? sin_q : cos_q;
  assign cm       = quad_q[0] ? s0 : c0;
  assign sm       = quad_q[0] ? c0 : s0;
  assign cn       = quad_q[0] ^ quad_q[1];
  assign sn       = quad_q[1];
  assign tm       = cmd_i.axis ? sm : cm;
  assign step_neg = sneg_q ^ (cmd_i.axis ? sn : cn);

  // Shared multiplier
  logic [MUL_W-1:0] mul_a, mul_b;
  logic             mul_en;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd_i.op)
      OP_M_DIST: begin
        mul_a = MUL_W'(smag_q[COUNT_WIDTH-1:0]);
        mul_b = dpt_q;
      end
      OP_M_T: begin
        mul_a = MUL_W'(u_q);
        mul_b = MUL_W'(PI_HALF_Q30);
      end
      OP_M_T2: begin
        mul_a = MUL_W'(t_q);
        mul_b = MUL_W'(t_q);
      end
      OP_M_P: begin
        mul_a = MUL_W'(t2_q);
        mul_b = MUL_W'(p_q);
      end
      OP_M_SIN: begin
        mul_a = MUL_W'(t_q);
        mul_b = MUL_W'(p_q);
      end
      OP_M_HI: begin
        mul_a = MUL_W'(dsm_q[DSM_W-1:MUL_W]);
        mul_b = MUL_W'(tm);
      end
      OP_M_LO: begin
        mul_a = dsm_q[MUL_W-1:0];
        mul_b = MUL_W'(tm);
      end
      OP_M_HEAD: begin
        mul_a = hd_q;
        mul_b = hpt_q;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Step magnitude, clamp and saturating add
  logic [FULL_W-1:0]        full;
  logic [MAG_W-1:0]         mag_raw, mag;
  logic signed [POS_W-1:0]  pos_sel;
  logic signed [SUMP_W-1:0] pos_x, mag_x, pos_r;
  logic signed [POS_W-1:0]  pos_new;
  logic [DSM_W-1:0]         dsm_d;
  logic [P_W-1:0]           q30_prod;

  assign q30_prod = prod_q[Q_FRAC +: P_W];
  assign full     = FULL_W'({hi_lo_q, {MUL_W{1'b0}}}) + FULL_W'(prod_q[LO_W-1:0]);
  assign mag_raw  = full[FULL_W-1:TRIG_BITS];
  assign mag      = (hi_big_q || mag_raw > (MAG_W'(1) << CAP_POS)) ?
                    (MAG_W'(1) << CAP_POS) : mag_raw;
  assign pos_sel  = cmd_i.axis ? y_q : x_q;
  assign pos_x    = SUMP_W'(pos_sel);
  assign mag_x    = signed'(SUMP_W'(mag));
  assign pos_r    = step_neg ? (pos_x - mag_x) : (pos_x + mag_x);

  always_comb begin
    if (pos_r[SUMP_W-1:POS_W-1] == '0 || pos_r[SUMP_W-1:POS_W-1] == '1) begin
      pos_new = pos_r[POS_W-1:0];
    end else if (pos_r[SUMP_W-1]) begin
      pos_new = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      pos_new = {1'b0, {(POS_W-1){1'b1}}};
    end
  end

  // full count range: the low bits are zero, the product is a shift
  assign dsm_d = smag_q[COUNT_WIDTH] ? (DSM_W'(dpt_q) << (COUNT_WIDTH - DIST_SHIFT)) :
                 prod_q[COUNT_WIDTH+MUL_W-1:DIST_SHIFT];

  // Working registers
  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    case (cmd_i.op)
      OP_START: begin
        lc_q <= in_data_i[COUNT_WIDTH-1:0];
        rc_q <= in_data_i[POS_W +: COUNT_WIDTH];
        pv_q <= signed'(in_data_i[2*POS_W +: POS_W]);
      end
      OP_PREP: begin
        smag_q <= smag;
        sneg_q <= sum[SUM_W-1];
        hd_q   <= hdw[ANG_W-1:0];
        u_q    <= u_ang;
        swap_q <= fold;
        quad_q <= head_q[ANG_W-1:U_W];
      end
      OP_W_DSM: dsm_q <= dsm_d;
      OP_W_T:   t_q   <= prod_q[Q_FRAC +: T_W];
      OP_W_T2: begin
        t2_q <= prod_q[Q_FRAC +: T_W];
        p_q  <= S9;
      end
      OP_W_PS:  p_q <= sin_coef(cmd_i.idx) - q30_prod;
      OP_W_PC:  p_q <= cos_coef(cmd_i.idx) - q30_prod;
      OP_W_SIN: begin
        sin_q <= to_trig(q30_prod);
        p_q   <= K10;
      end
      OP_W_COS: cos_q <= to_trig(Q30_ONE - q30_prod);
      OP_W_HI: begin
        hi_big_q <= |prod_q[HI_W-1:HI_KEEP_W];
        hi_lo_q  <= prod_q[HI_KEEP_W-1:0];
      end
      default: ;
    endcase
    if (cmd_i.load_out) begin
      out_q <= {head_q, y_q, x_q};
    end
  end

  // Configuration and odometry state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dpt_q    <= CFG_W'(259204);
      hpt_q    <= CFG_W'(3641130);
      last_l_q <= '0;
      last_r_q <= '0;
      x_q      <= '0;
      y_q      <= '0;
      head_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DIST: dpt_q <= cfg_data_i;
          CFG_HEAD: hpt_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (cmd_i.op)
        OP_W_POS: begin
          if (cmd_i.axis) begin
            y_q <= pos_new;
          end else begin
            x_q <= pos_new;
          end
        end
        OP_W_HEAD: begin
          head_q   <= head_q + prod_q[ANG_W-1:0];
          last_l_q <= lc_q;
          last_r_q <= rc_q;
        end
        OP_SET_X: x_q <= pv_q;
        OP_SET_Y: y_q <= pv_q;
        default: ;
      endcase
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== rtl/differential_drive_odometry.sv =====
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: left, right, position_value; tuser: kind
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: x_pos, y_pos, heading
// cfg       in   cfg_we_i (no wait)            cfg_idx_i, cfg_data_i
//
// Encoder, set-x/set-y and kind 3 items are taken only while the sequencer is idle, so
// the next item waits until the last one is finished. The block has a single 32x32 multiplier,
// used in turn for the distance, the sin/cos Horner chains, both position steps and the heading.
// Reset (async, active low) clears position, heading, last counts and loads the
// register defaults. A result sits in the output register; the next item is taken
// while it waits, and only the final write-back waits for m_axis_tready.
module differential_drive_odometry
  import ddo_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [31:0] left_count, [63:32] right_count,
                                                // [95:64] position_value
  input  logic [KIND_W-1:0]     s_axis_tuser,   // [1:0] kind
  // result items
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [31:0] x_pos, [63:32] y_pos,
                                                // [95:64] heading
  // register writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i
);

  dp_cmd_t cmd;

  // sequencer: handshakes and operation order
  ddo_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_kind_i  (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd)
  );

  // arithmetic, odometry state and the output register
  ddo_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata),
    .out_data_o (m_axis_tdata)
  );

endmodule

// ===== test/tb.sv =====
module tb;
  import ddo_pkg::*;

  // Kind 3 has no package name: the block leaves its state alone.
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  // Q30 Taylor coefficients for the first-octant sin/cos
  localparam longint unsigned ONE_Q30     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned SIN_A3      = 64'd178956971;
  localparam longint unsigned SIN_A5      = 64'd8947849;
  localparam longint unsigned SIN_A7      = 64'd213044;
  localparam longint unsigned SIN_A9      = 64'd2959;
  localparam longint unsigned COS_A2      = 64'd536870912;
  localparam longint unsigned COS_A4      = 64'd44739243;
  localparam longint unsigned COS_A6      = 64'd1491308;
  localparam longint unsigned COS_A8      = 64'd26631;
  localparam longint unsigned COS_A10     = 64'd296;
  localparam longint unsigned STEP_CAP    = 64'd1 << 34;
  localparam longint unsigned CNT_MASK    = (64'd1 << COUNT_WIDTH) - 64'd1;

  localparam int RAND_PHASES     = 6;
  localparam int ITEMS_PER_PHASE = 210;
  localparam int MAX_REPORTS     = 10;

  // Packed as on m_axis_tdata: x in the low word, heading in the high word.
  typedef struct packed {
    logic        [31:0] heading;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } pose_t;

  // Pose tracker: own copy of the registers and of the odometry state,
  // plus the queue of poses still owed by the block.
  class odometry_scoreboard;
    logic        [31:0] dist_per_tick = 32'd259204;
    logic        [31:0] head_per_tick = 32'd3641130;
    logic        [31:0] last_l        = '0;
    logic        [31:0] last_r        = '0;
    logic signed [31:0] x_now         = '0;
    logic signed [31:0] y_now         = '0;
    logic        [31:0] hdg_now       = '0;
    pose_t              pose_q[$];
    int                 mismatches    = 0;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_DIST) dist_per_tick = val;
      else if (idx == CFG_HEAD) head_per_tick = val;
    endfunction

    function int pending();
      return pose_q.size();
    endfunction

    function longint unsigned mul_q30(longint unsigned a, longint unsigned b);
      return (a * b) >> 30;
    endfunction

    // u: angle in 2^-32 turn units, 0..2^29
    function longint unsigned sin_q30(longint unsigned u);
      longint unsigned t, t2, p;
      t  = (u * HALF_PI_Q30) >> 30;
      t2 = mul_q30(t, t);
      p  = SIN_A9;
      p  = SIN_A7 - mul_q30(t2, p);
      p  = SIN_A5 - mul_q30(t2, p);
      p  = SIN_A3 - mul_q30(t2, p);
      p  = ONE_Q30 - mul_q30(t2, p);
      return mul_q30(t, p);
    endfunction

    function longint unsigned cos_q30(longint unsigned u);
      longint unsigned t, t2, p;
      t  = (u * HALF_PI_Q30) >> 30;
      t2 = mul_q30(t, t);
      p  = COS_A10;
      p  = COS_A8 - mul_q30(t2, p);
      p  = COS_A6 - mul_q30(t2, p);
      p  = COS_A4 - mul_q30(t2, p);
      p  = COS_A2 - mul_q30(t2, p);
      return ONE_Q30 - mul_q30(t2, p);
    endfunction

    // round half up from Q30 to TRIG_BITS fraction bits
    function longint unsigned to_trig(longint unsigned v);
      return (v + (64'd1 << (29 - TRIG_BITS))) >> (30 - TRIG_BITS);
    endfunction

    function void trig_of(input logic [31:0] ang,
                          output longint unsigned cmag, output bit cneg,
                          output longint unsigned smag, output bit sneg);
      longint unsigned r, s0, c0;
      r = {34'd0, ang[29:0]};
      if (r <= (64'd1 << 29)) begin
        s0 = to_trig(sin_q30(r));
        c0 = to_trig(cos_q30(r));
      end else begin
        s0 = to_trig(cos_q30((64'd1 << 30) - r));
        c0 = to_trig(sin_q30((64'd1 << 30) - r));
      end
      case (ang[31:30])
        2'd0: begin cmag = c0; cneg = 1'b0; smag = s0; sneg = 1'b0; end
        2'd1: begin cmag = s0; cneg = 1'b1; smag = c0; sneg = 1'b0; end
        2'd2: begin cmag = c0; cneg = 1'b1; smag = s0; sneg = 1'b1; end
        default: begin cmag = s0; cneg = 1'b0; smag = c0; sneg = 1'b1; end
      endcase
    endfunction

    // wrapped encoder difference, two's complement over COUNT_WIDTH bits
    function longint count_step(logic [31:0] cur, logic [31:0] prev);
      longint unsigned d;
      d = ({32'd0, cur} - {32'd0, prev}) & CNT_MASK;
      if (d[COUNT_WIDTH-1]) return longint'(d) - longint'(64'd1 << COUNT_WIDTH);
      return longint'(d);
    endfunction

    // pos +/- (dsm * trig >> TRIG_BITS), step capped, result saturated
    function logic signed [31:0] step_axis(logic signed [31:0] pos, longint unsigned dsm,
                                           longint unsigned tm, bit neg);
      longint unsigned hi, lo, mag;
      longint r;
      hi = (dsm >> 32) * tm;
      lo = (dsm & 64'hFFFF_FFFF) * tm;
      if (hi >= (64'd1 << (TRIG_BITS + 2))) begin
        mag = STEP_CAP;
      end else begin
        mag = ((hi << 32) + lo) >> TRIG_BITS;
        if (mag > STEP_CAP) mag = STEP_CAP;
      end
      r = neg ? longint'(pos) - longint'(mag) : longint'(pos) + longint'(mag);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[31:0];
    endfunction

    function pose_t advance_pose(logic [KIND_W-1:0] kind, logic [31:0] lc,
                                 logic [31:0] rc, logic [31:0] pv);
      longint          dl, dr, total;
      longint unsigned tmag, dsm, cm, sm;
      bit              cn, sn, neg;
      logic [31:0]     turn;
      case (kind)
        KIND_ENC: begin
          dl    = count_step(lc, last_l);
          dr    = count_step(rc, last_r);
          total = dl + dr;
          neg   = total < 0;
          tmag  = neg ? longint'(-total) : longint'(total);
          dsm   = (tmag * {32'd0, dist_per_tick}) >> 8;
          // move along the heading held before this item
          trig_of(hdg_now, cm, cn, sm, sn);
          x_now   = step_axis(x_now, dsm, cm, neg != cn);
          y_now   = step_axis(y_now, dsm, sm, neg != sn);
          turn    = 32'(dl - dr);
          hdg_now = hdg_now + turn * head_per_tick;
          last_l  = lc & 32'(CNT_MASK);
          last_r  = rc & 32'(CNT_MASK);
        end
        KIND_SET_X: x_now = pv;
        KIND_SET_Y: y_now = pv;
        default: ;
      endcase
      return '{heading: hdg_now, y: y_now, x: x_now};
    endfunction

    function void note_item(logic [KIND_W-1:0] kind, logic [31:0] lc,
                            logic [31:0] rc, logic [31:0] pv);
      pose_q.push_back(advance_pose(kind, lc, rc, pv));
    endfunction

    function void report_field(string fname, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch %s: expected %h, got %h", fname, want, got);
    endfunction

    function void check_pose(logic [OUT_DATA_W-1:0] data);
      pose_t got, want;
      got = pose_t'(data);
      if (pose_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: x %h y %h heading %h", got.x, got.y, got.heading);
        return;
      end
      want = pose_q.pop_front();
      if (got.x !== want.x) report_field("x_pos", want.x, got.x);
      if (got.y !== want.y) report_field("y_pos", want.y, got.y);
      if (got.heading !== want.heading) report_field("heading", want.heading, got.heading);
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // [31:0] left, [63:32] right, [95:64] position_value
  logic [KIND_W-1:0]     s_axis_tuser;   // [1:0] kind
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // [31:0] x_pos, [63:32] y_pos, [95:64] heading
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_W-1:0]      cfg_data_i;

  odometry_scoreboard sb = new();
  bit                 calm = 1'b0;   // set in the last phase: no idling on either side
  logic [31:0]        gen_l = '0;    // counts of the last encoder item sent
  logic [31:0]        gen_r = '0;

  differential_drive_odometry u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: sample at the rising edge, outputs settle after it.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_pose(m_axis_tdata);
  end

  // Receiver: runs of ready broken by stall bursts.
  initial begin : ready_gen
    int n;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      n = $urandom_range(1, 40);
      repeat (n) begin
        @(negedge clk_i);
        m_axis_tready = 1'b1;
      end
      if (!calm) begin
        n = $urandom_range(1, 13);
        repeat (n) begin
          @(negedge clk_i);
          m_axis_tready = 1'b0;
        end
      end
    end
  end

  // Present one item at the falling edge and hold it until it is taken.
  // tvalid stays high afterwards so back-to-back items need no gap.
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [31:0] lc,
                           input logic [31:0] rc, input logic [31:0] pv);
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {pv, rc, lc};
    s_axis_tuser  = kind;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(kind, lc, rc, pv);
    if (kind == KIND_ENC) begin
      gen_l = lc;
      gen_r = rc;
    end
  endtask

  task automatic input_gap();
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 13);
      repeat (n) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
      end
    end
  endtask

  // Every item returns a pose, so an empty queue means the block is idle.
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Mostly small wheel motion so the pose stays in range; the rest is
  // full-range counts, near-wrap jumps, position loads and spare kinds.
  task automatic random_item();
    int          sel;
    logic [31:0] lc, rc;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      lc = gen_l + $urandom_range(0, 1200) - 32'd600;
      rc = gen_r + $urandom_range(0, 1200) - 32'd600;
      send_item(KIND_ENC, lc, rc, $urandom);
    end else if (sel < 63) begin
      send_item(KIND_ENC, $urandom, $urandom, $urandom);
    end else if (sel < 70) begin
      lc = gen_l + 32'h7FFF_FFF0 + $urandom_range(0, 31);
      rc = ($urandom_range(0, 1) != 0) ? gen_r + 32'h7FFF_FFF0 + $urandom_range(0, 31)
                                       : gen_r + $urandom_range(0, 64) - 32'd32;
      send_item(KIND_ENC, lc, rc, $urandom);
    end else if (sel < 83) begin
      send_item(KIND_SET_X, $urandom, $urandom,
                ($urandom_range(0, 7) == 0) ? 32'h7FFF_FFFF : $urandom);
    end else if (sel < 96) begin
      send_item(KIND_SET_Y, $urandom, $urandom,
                ($urandom_range(0, 7) == 0) ? 32'h8000_0000 : $urandom);
    end else begin
      send_item(KIND_SPARE, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin : stim
    int          ph;
    logic [31:0] dist_val, head;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_ENC;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_DIST;
    cfg_data_i    = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed, on the reset register values
    send_item(KIND_ENC, 32'd0, 32'd0, $urandom);               // no motion
    send_item(KIND_ENC, 32'd1000, 32'd1000, $urandom);         // straight at heading 0
    send_item(KIND_ENC, 32'd1600, 32'd1200, $urandom);         // arc
    send_item(KIND_SPARE, $urandom, $urandom, $urandom);       // unused kind
    send_item(KIND_SET_X, $urandom, $urandom, 32'h7FFF_FFFF);
    send_item(KIND_SET_Y, $urandom, $urandom, 32'h8000_0000);
    send_item(KIND_ENC, 32'h7FFF_FFFF, 32'h7FFF_FFFF, $urandom); // huge step, saturate
    send_item(KIND_ENC, 32'h8000_0000, 32'h8000_0000, $urandom); // counts wrap by +1
    send_item(KIND_ENC, 32'd0, 32'd0, $urandom);               // largest backward sum
    send_item(KIND_SET_X, $urandom, $urandom, 32'd0);
    send_item(KIND_SET_Y, $urandom, $urandom, 32'd0);
    send_item(KIND_ENC, 32'h7FFF_FFFF, 32'h8000_0000, $urandom); // heading delta wraps

    // Eighth-turn per tick of difference: walk the heading through every
    // octant boundary, then step back once.
    wait_idle();
    write_reg(CFG_DIST, 32'h0100_0000);
    write_reg(CFG_HEAD, 32'h2000_0000);
    send_item(KIND_SET_X, $urandom, $urandom, 32'd0);
    send_item(KIND_SET_Y, $urandom, $urandom, 32'd0);
    repeat (9) send_item(KIND_ENC, gen_l + 32'd101, gen_r + 32'd100, $urandom);
    send_item(KIND_ENC, gen_l + 32'd100, gen_r + 32'd101, $urandom);

    // Random phases, one register setting each
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: begin dist_val = 32'd259204;     head = 32'd3641130;    end
        1: begin dist_val = 32'd0;          head = 32'd0;          end
        2: begin dist_val = 32'hFFFF_FFFF;  head = 32'hFFFF_FFFF;  end
        3: begin dist_val = 32'd1;          head = 32'd1;          end
        4: begin dist_val = $urandom;       head = $urandom;       end
        default: begin dist_val = $urandom_range(0, 1 << 22); head = $urandom; end
      endcase
      write_reg(CFG_DIST, dist_val);
      write_reg(CFG_HEAD, head);
      if (ph == RAND_PHASES - 1) calm = 1'b1;
      repeat (ITEMS_PER_PHASE) begin
        random_item();
        input_gap();
      end
    end

    wait_idle();
    repeat (60) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
